// ===== src/psv_pkg.sv =====
// psv_pkg: operation codes, field widths and noise constants for the plucked string voice
// no dependencies; imported by every module of the voice
`timescale 1ns / 1ps
`default_nettype none

package psv_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PERIOD_W = 12;
    localparam int GAIN_W   = 16;
    localparam int LFSR_W   = 16;
    localparam int OP_W     = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [LFSR_W-1:0]   t_lfsr;

    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_START = 2'd1;
    localparam t_op OP_STOP  = 2'd2;

    localparam t_lfsr LFSR_TAPS  = 16'hB400;
    localparam t_lfsr SEED_RESET = 16'd44257;
    localparam t_sample NOISE_OFFSET = 16'd16384;

endpackage

`default_nettype wire

// ===== src/psv_in_if.sv =====
// psv_in_if: request channel of the voice (op, pitch period, decay gain)
// depends on psv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface psv_in_if
    import psv_pkg::*;
();
    logic                valid;
    logic                ready;
    t_op                 op;
    logic [PERIOD_W-1:0] pitch_period;
    logic [GAIN_W-1:0]   decay_gain;

    modport source (output valid, output op, output pitch_period, output decay_gain,
                    input ready);
    modport sink   (input valid, input op, input pitch_period, input decay_gain,
                    output ready);
endinterface

`default_nettype wire

// ===== src/psv_out_if.sv =====
// psv_out_if: result channel of the voice (sample, voice active)
// depends on psv_pkg
`timescale 1ns / 1ps
`default_nettype none

interface psv_out_if
    import psv_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    voice_active;

    modport source (output valid, output sample, output voice_active, input ready);
    modport sink   (input valid, input sample, input voice_active, output ready);
endinterface

`default_nettype wire

// ===== src/psv_delay_ram.sv =====
// psv_delay_ram: delay line store, one write port and two registered read ports
// depends on psv_pkg
`timescale 1ns / 1ps
`default_nettype none

module psv_delay_ram
    import psv_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic    i_clk,
    input  wire logic    i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_sample i_wdata,
    input  wire logic    i_re,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output      t_sample o_rdata_a,
    output      t_sample o_rdata_b
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata_a;
    t_sample r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== src/psv_noise.sv =====
// psv_noise: galois lfsr noise source, shift right, gives entries in [-16384, 16383]
// depends on psv_pkg
`timescale 1ns / 1ps
`default_nettype none

module psv_noise
    import psv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_lfsr i_seed,
    input  wire logic  i_step,
    output      t_sample o_noise
);

    t_lfsr r_lfsr;
    t_lfsr n_lfsr;
    t_lfsr w_shifted;

    assign w_shifted = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);
    assign o_noise   = {1'b0, w_shifted[14:0]} - NOISE_OFFSET;

    always_comb begin
        n_lfsr = r_lfsr;
        if (i_load) begin
            n_lfsr = (i_seed == '0) ? t_lfsr'(1) : i_seed;
        end else if (i_step) begin
            n_lfsr = w_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= SEED_RESET;
        end else begin
            r_lfsr <= n_lfsr;
        end
    end

endmodule

`default_nettype wire

// ===== src/plucked_string_voice.sv =====
// plucked_string_voice: one karplus-strong plucked string voice, top level and control
// depends on psv_pkg, psv_in_if, psv_out_if, psv_delay_ram, psv_noise
//
//  channel   dir  handshake        payload
//  i_in      in   valid / ready    op, pitch_period, decay_gain
//  o_out     out  valid / ready    sample, voice_active
//  i_cfg     in   i_cfg_we         i_cfg_wdata (noise seed, loads the lfsr)
//
//  tick, stop, the unused code and a start on a sounding voice go through
//  the request state, then the execute state
//  start on a silent voice adds a fill of 2 * pitch_period delay entries (length capped by
//  MAX_LENGTH, pitch_period 0 counts as 1): one delay entry per cycle through the single ram write port
//  synchronous reset; no clearing pass, entries are filled by start before being read
//  execute holds while the output register is full and not taken
`timescale 1ns / 1ps
`default_nettype none

module plucked_string_voice
    import psv_pkg::*;
#(
    parameter int MAX_LENGTH = 4096
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire t_lfsr i_cfg_wdata,
    psv_in_if.sink     i_in,
    psv_out_if.source  o_out
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int CW = (LW > PERIOD_W + 1) ? LW : PERIOD_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]        r_state,   n_state;
    t_op               r_op,      n_op;
    logic [PERIOD_W-1:0] r_period;
    logic [GAIN_W-1:0] r_gain_in;
    logic [GAIN_W-1:0] r_decay,   n_decay;
    logic [LW-1:0]     r_len,     n_len;
    logic [AW-1:0]     r_pos,     n_pos;
    logic [AW-1:0]     r_cnt,     n_cnt;
    logic              r_sounding, n_sounding;
    logic              r_out_valid, n_out_valid;
    t_sample           r_sample,  n_sample;
    logic              r_active,  n_active;

    logic              w_accept;
    logic              w_slot_free;
    logic [AW-1:0]     w_pos;
    logic [LW-1:0]     w_nxt_full;
    logic [AW-1:0]     w_nxt;
    logic [PERIOD_W-1:0] w_period_nz;
    logic [CW-1:0]     w_len_req;
    logic [LW-1:0]     w_len_new;
    t_sample           w_rd_a;
    t_sample           w_rd_b;
    logic signed [SAMPLE_W:0]   w_sum;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic signed [SAMPLE_W+GAIN_W:0] w_prod;
    t_sample           w_noise;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    t_sample           w_wdata;
    logic              w_step;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE);

    // current and next positions around the loop
    assign w_pos      = (LW'(r_pos) >= r_len) ? '0 : r_pos;
    assign w_nxt_full = LW'(w_pos) + LW'(1);
    assign w_nxt      = (w_nxt_full >= r_len) ? '0 : w_nxt_full[AW-1:0];

    assign w_period_nz = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign w_len_req   = CW'({w_period_nz, 1'b0});
    assign w_len_new   = (w_len_req > CW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : LW'(w_len_req);

    // feedback filter: floor average, then q0.16 gain
    assign w_sum  = $signed({w_rd_a[SAMPLE_W-1], w_rd_a}) + $signed({w_rd_b[SAMPLE_W-1], w_rd_b});
    assign w_avg  = w_sum[SAMPLE_W:1];
    assign w_prod = w_avg * $signed({1'b0, r_decay});

    psv_delay_ram #(
        .DEPTH (MAX_LENGTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_accept),
        .i_raddr_a (w_pos),
        .i_raddr_b (w_nxt),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    psv_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_cfg_we),
        .i_seed  (i_cfg_wdata),
        .i_step  (w_step),
        .o_noise (w_noise)
    );

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_decay     = r_decay;
        n_len       = r_len;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_sounding  = r_sounding;
        n_out_valid = r_out_valid && !o_out.ready;
        n_sample    = r_sample;
        n_active    = r_active;
        w_we        = 1'b0;
        w_waddr     = w_pos;
        w_wdata     = w_prod[SAMPLE_W+GAIN_W-1:GAIN_W];
        w_step      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = i_in.op;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == OP_START && !r_sounding) begin
                    n_len   = w_len_new;
                    n_pos   = '0;
                    n_cnt   = '0;
                    n_decay = r_gain_in;
                    n_state = S_FILL;
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_sample    = '0;
                    n_state     = S_IDLE;
                    case (r_op)
                        OP_TICK: begin
                            if (r_sounding) begin
                                n_sample = w_rd_a;
                                w_we     = 1'b1;
                                n_pos    = w_nxt;
                            end
                            n_active = r_sounding;
                        end
                        OP_START: begin
                            n_active = 1'b1;
                        end
                        OP_STOP: begin
                            n_sounding = 1'b0;
                            n_active   = 1'b0;
                        end
                        default: begin
                            n_active = r_sounding;
                        end
                    endcase
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_cnt;
                w_wdata = w_noise;
                w_step  = 1'b1;
                n_cnt   = r_cnt + AW'(1);
                if (LW'(r_cnt) == r_len - LW'(1)) begin
                    n_sounding = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TICK;
            r_decay     <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_sounding  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_decay     <= n_decay;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_sounding  <= n_sounding;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_active <= n_active;
        if (w_accept) begin
            r_period  <= i_in.pitch_period;
            r_gain_in <= i_in.decay_gain;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample       = r_sample;
    assign o_out.voice_active = r_active;

    a_fill_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !r_sounding)
        else $error("voice sounding during delay fill");

    a_len_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sounding |-> (r_len >= LW'(2) && LW'(r_pos) < r_len))
        else $error("sounding with bad length or position");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (LW'(r_cnt) < r_len))
        else $error("fill count beyond delay length");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_op == OP_TICK && !r_sounding && w_slot_free)
        |=> (o_out.valid && o_out.sample == '0 && !o_out.voice_active))
        else $error("silent tick gave a non-zero sample");

endmodule

`default_nettype wire

// ===== bench/plucked_string_voice_tb.sv =====
// plucked_string_voice_tb: self-checking bench for the plucked string voice, with an
// in-bench voice predictor in a scoreboard class, bursty requests and a stalling receiver
// depends on psv_pkg, psv_in_if, psv_out_if and plucked_string_voice
`timescale 1ns / 1ps

module plucked_string_voice_tb;
    import psv_pkg::*;

    localparam int VOICE_DEPTH     = 4096;
    localparam int RANDOM_REQUESTS = 1450;
    localparam int PHASES          = 5;
    localparam t_op OP_UNUSED      = 2'd3;

    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [GAIN_W-1:0]   t_gain;

    typedef struct packed {
        t_sample sample;
        logic    active;
    } t_voice_result;

    class t_voice_scoreboard;
        t_sample       delay_mem [VOICE_DEPTH];
        int unsigned   loop_len;
        int unsigned   read_pos;
        bit            sounding;
        t_gain         decay;
        t_lfsr         lfsr;
        t_voice_result due_q[$];
        int unsigned   mismatches;
        int unsigned   checked;
        int unsigned   notes;
        int unsigned   ticks;

        function new();
            loop_len   = 0;
            read_pos   = 0;
            sounding   = 1'b0;
            decay      = '0;
            lfsr       = SEED_RESET;
            mismatches = 0;
            checked    = 0;
            notes      = 0;
            ticks      = 0;
        endfunction

        function void load_seed(t_lfsr seed);
            lfsr = (seed == '0) ? t_lfsr'(1) : seed;
        endfunction

        // galois step, shift right
        function t_sample next_noise();
            logic fb;
            fb   = lfsr[0];
            lfsr = lfsr >> 1;
            if (fb) begin
                lfsr = lfsr ^ LFSR_TAPS;
            end
            return t_sample'({1'b0, lfsr[14:0]}) - NOISE_OFFSET;
        endfunction

        function t_sample pluck_step();
            int unsigned nxt;
            int          sum_ab;
            longint      scaled;
            t_sample     now_val;
            if (!sounding || loop_len == 0) begin
                return '0;
            end
            if (read_pos >= loop_len) begin
                read_pos = 0;
            end
            nxt = read_pos + 1;
            if (nxt >= loop_len) begin
                nxt = 0;
            end
            now_val = delay_mem[read_pos];
            sum_ab  = int'($signed(delay_mem[read_pos])) + int'($signed(delay_mem[nxt]));
            // floor average, then floor of the q0.16 product
            scaled  = longint'(sum_ab >>> 1) * longint'({1'b0, decay});
            delay_mem[read_pos] = t_sample'(scaled >>> 16);
            read_pos = nxt;
            return now_val;
        endfunction

        function void note_request(t_op op, t_period period, t_gain gain);
            t_voice_result res;
            int unsigned   span;
            int unsigned   idx;
            res.sample = '0;
            case (op)
                OP_TICK: begin
                    res.sample = pluck_step();
                    ticks++;
                end
                OP_START: begin
                    if (!sounding) begin
                        span = (period == '0) ? 2 : 2 * period;
                        if (span > VOICE_DEPTH) begin
                            span = VOICE_DEPTH;
                        end
                        loop_len = span;
                        for (idx = 0; idx < span; idx++) begin
                            delay_mem[idx] = next_noise();
                        end
                        sounding = 1'b1;
                        read_pos = 0;
                        decay    = gain;
                        notes++;
                    end
                end
                OP_STOP: begin
                    sounding = 1'b0;
                end
                default: begin
                end
            endcase
            res.active = sounding;
            due_q.push_back(res);
        endfunction

        function void check_result(t_sample got_sample, logic got_active);
            t_voice_result want;
            checked++;
            if (due_q.size() == 0) begin
                $error("unexpected result: sample %0d, voice_active %0b",
                       $signed(got_sample), got_active);
                mismatches++;
                return;
            end
            want = due_q.pop_front();
            if (got_sample !== want.sample) begin
                $error("sample mismatch: expected %0d, actual %0d",
                       $signed(want.sample), $signed(got_sample));
                mismatches++;
            end
            if (got_active !== want.active) begin
                $error("voice_active mismatch: expected %0b, actual %0b",
                       want.active, got_active);
                mismatches++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_lfsr i_cfg_wdata;

    psv_in_if  in_if ();
    psv_out_if out_if ();

    t_voice_scoreboard sb;

    int unsigned counted_requests = 0;
    int unsigned burst_left       = 0;
    int unsigned seeds_written    = 0;

    logic [9:0]  stall_clock = '0;
    logic [1:0]  stall_mode  = '0;
    int unsigned hold_left   = 0;

    plucked_string_voice #(
        .MAX_LENGTH (VOICE_DEPTH)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: checks each accepted result, stall pattern is redrawn whenever stall_clock[7:0] wraps to zero
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            sb.check_result(out_if.sample, out_if.voice_active);
        end
        stall_clock <= stall_clock + 1'b1;
        if (stall_clock[7:0] == 8'd0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        case (stall_mode)
            2'd0: begin
                out_if.ready <= 1'b1;
            end
            2'd1: begin
                out_if.ready <= 1'($urandom_range(0, 1));
            end
            2'd2: begin
                out_if.ready <= (stall_clock[1:0] == 2'd0);
            end
            default: begin
                if (hold_left != 0) begin
                    hold_left    <= hold_left - 1;
                    out_if.ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    hold_left    <= $urandom_range(3, 12);
                    out_if.ready <= 1'b0;
                end else begin
                    out_if.ready <= 1'b1;
                end
            end
        endcase
    end

    task automatic send_request(t_op op, t_period period, t_gain gain);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        // ignored requests do not count towards the random total
        if (op != OP_UNUSED && !(op == OP_START && sb.sounding)) begin
            counted_requests++;
        end
        in_if.valid        <= 1'b1;
        in_if.op           <= op;
        in_if.pitch_period <= period;
        in_if.decay_gain   <= gain;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_request(op, period, gain);
        burst_left--;
    endtask

    task automatic send_noise();
        t_op     op;
        t_period period;
        op     = t_op'($urandom_range(0, 3));
        period = sb.sounding ? t_period'($urandom) : t_period'($urandom_range(0, 31));
        send_request(op, period, t_gain'($urandom));
    endtask

    task automatic play_note();
        int unsigned roll;
        int unsigned span;
        int unsigned limit;
        int unsigned n_ticks;
        t_period     period;
        t_gain       gain;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            period = '0;
        end else if (roll < 85) begin
            period = t_period'($urandom_range(1, 24));
        end else if (roll < 98) begin
            period = t_period'($urandom_range(25, 400));
        end else begin
            period = t_period'($urandom_range(401, 4095));
        end
        gain = ($urandom_range(0, 3) == 0) ? t_gain'($urandom)
                                           : t_gain'($urandom_range(16'hE000, 16'hFFFF));
        send_request(OP_START, period, gain);
        span  = (period == '0) ? 2 : 2 * period;
        limit = (span * 3 > 150) ? 150 : span * 3;
        n_ticks = $urandom_range(1, limit);
        repeat (n_ticks) begin
            if ($urandom_range(0, 19) == 0) begin
                send_noise();
            end
            send_request(OP_TICK, t_period'($urandom), t_gain'($urandom));
        end
        if ($urandom_range(0, 9) < 6) begin
            send_request(OP_STOP, t_period'($urandom), t_gain'($urandom));
            repeat ($urandom_range(0, 2)) begin
                send_request(OP_TICK, t_period'($urandom), t_gain'($urandom));
            end
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_seed(t_lfsr seed);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        sb.load_seed(seed);
        i_cfg_we <= 1'b0;
        seeds_written++;
    endtask

    initial begin
        int phase;
        sb = new();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_if.valid        <= 1'b0;
        in_if.op           <= OP_TICK;
        in_if.pitch_period <= '0;
        in_if.decay_gain   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // silent voice, then shortest loop with wraparound and an ignored start
        send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
        send_request(OP_UNUSED, '0, '0);
        send_request(OP_START, '0, 16'hFFFF);
        send_request(OP_START, 12'hFFF, '0);
        repeat (4) send_request(OP_TICK, '0, '0);
        send_request(OP_UNUSED, 12'hFFF, 16'hFFFF);
        send_request(OP_STOP, '0, '0);
        // zero decay, then saturated and exactly full delay lengths
        send_request(OP_START, 12'd1, '0);
        repeat (3) send_request(OP_TICK, 12'hFFF, 16'hFFFF);
        send_request(OP_STOP, 12'hFFF, 16'hFFFF);
        send_request(OP_START, 12'hFFF, 16'h8000);
        repeat (3) send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
        send_request(OP_START, 12'd2048, 16'hFFFF);
        repeat (2) send_request(OP_TICK, '0, '0);
        send_request(OP_STOP, '0, '0);
        counted_requests = 0;

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                settle();
                case (phase)
                    1:       write_seed('0);
                    2:       write_seed(16'hFFFF);
                    3:       write_seed(16'h0001);
                    default: write_seed(t_lfsr'($urandom_range(1, 65535)));
                endcase
            end
            while (counted_requests < RANDOM_REQUESTS * (phase + 1) / PHASES) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_noise();
                end else begin
                    play_note();
                end
            end
        end
        settle();

        $display("covered %0d results: %0d notes started, %0d ticks, %0d noise seeds loaded",
                 sb.checked, sb.notes, sb.ticks, seeds_written);
        if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.due_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
